// ----- sv/assert_macros.svh -----
// Assertion macros for the checker file.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define PFRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define PFRP_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- sv/pfrp_pkg.sv -----
// Shared types and constants of the packed framebuffer rectangle plotter.
// No dependencies.
package pfrp_pkg;

    localparam int DEF_MAX_WIDTH      = 256;
    localparam int DEF_MAX_HEIGHT     = 256;
    localparam int DEF_BITS_PER_PIXEL = 1;
    localparam int FRAME_BYTES        = 8192;
    localparam int COORD_W            = 14;

    localparam logic [5:0] ALIGN_DEFAULT = 6'd21;

    localparam logic [2:0] OP_SET_CURSOR = 3'd0;
    localparam logic [2:0] OP_PIXEL      = 3'd1;
    localparam logic [2:0] OP_BOX        = 3'd2;
    localparam logic [2:0] OP_FILL       = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;
    localparam logic [2:0] OP_READ       = 3'd5;
    localparam logic [2:0] OP_ACK        = 3'd6;

    localparam logic [1:0] CFG_FLIP     = 2'd0;
    localparam logic [1:0] CFG_WIDTH    = 2'd1;
    localparam logic [1:0] CFG_HEIGHT   = 2'd2;
    localparam logic [1:0] CFG_CONTRAST = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [2:0] flip;
        logic [8:0] ew;
        logic [8:0] eh;
        logic [7:0] contrast;
    } pfrp_cfg_t;

    typedef struct packed {
        logic        plot;
        logic        rd;
        coord_t      x;
        coord_t      y;
        logic [7:0]  val;
        logic [12:0] raddr;
    } pfrp_req_t;

    typedef struct packed {
        logic       done;
        logic       changed;
        logic [7:0] rdata;
    } pfrp_rsp_t;

endpackage

// ----- sv/pfrp_if.sv -----
// Command and result channels of the rectangle plotter.
// Plain valid/ready channels, no dependencies.
interface pfrp_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [5:0]         align_bits;
    logic [9:0]         rect_width;
    logic [9:0]         rect_height;
    logic [7:0]         intensity;
    logic [12:0]        byte_address;

    modport source (output valid, op, pos_x, pos_y, align_bits, rect_width, rect_height,
                    intensity, byte_address, input ready);
    modport sink   (input valid, op, pos_x, pos_y, align_bits, rect_width, rect_height,
                    intensity, byte_address, output ready);
endinterface

interface pfrp_rsp_if;
    logic               valid;
    logic               ready;
    logic [7:0]         read_data;
    logic               any_changed;
    logic               frame_dirty;
    logic signed [11:0] cursor_x_out;
    logic signed [11:0] cursor_y_out;

    modport source (output valid, read_data, any_changed, frame_dirty, cursor_x_out,
                    cursor_y_out, input ready);
    modport sink   (input valid, read_data, any_changed, frame_dirty, cursor_x_out,
                    cursor_y_out, output ready);
endinterface

// ----- sv/pfrp_pixel_unit.sv -----
// Pixel read-modify-write unit: flip, clip, pack and frame memory.
// Depends on pfrp_pkg.
module pfrp_pixel_unit
    import pfrp_pkg::*;
#(
    parameter int BITS_PER_PIXEL = DEF_BITS_PER_PIXEL
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  pfrp_cfg_t cfg,
    input  pfrp_req_t req,
    output logic      ready,
    output pfrp_rsp_t rsp
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int PPB = 8 / BITS_PER_PIXEL;
    localparam logic [7:0] PIX_MASK = 8'((1 << BITS_PER_PIXEL) - 1);

    typedef enum logic [2:0] {U_CLEAR, U_IDLE, U_ADDR, U_READ, U_CMP} ustate_t;

    ustate_t                   state_reg;
    logic [AW-1:0]             clr_cnt_reg;
    logic                      is_rd_reg;
    logic                      vis_reg;
    logic [7:0]                x_reg;
    logic [7:0]                y_reg;
    logic [BITS_PER_PIXEL-1:0] pix_reg;
    logic [2:0]                shift_reg;
    logic [AW-1:0]             mem_addr_reg;

    logic [7:0] mem [FRAME_BYTES];
    logic [7:0] rdata_q;

    coord_t ew_s, eh_s, sx, sy, tx, ty;
    logic   vis;
    logic [2:0] dsh;
    logic [7:0] iv, pvf;
    logic [BITS_PER_PIXEL-1:0] pix;

    logic [11:0] lin;
    logic [8:0]  dx;
    logic [7:0]  yoff;
    logic [20:0] addr_full;
    logic        addr_ok;
    logic [2:0]  shift;

    logic [7:0] old_pix, new_byte;
    logic       differ;
    logic       mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0] mem_wdata;

    always_comb
    begin
        ew_s = $signed({5'd0, cfg.ew});
        eh_s = $signed({5'd0, cfg.eh});
        sx = cfg.flip[2] ? req.y : req.x;
        sy = cfg.flip[2] ? req.x : req.y;
        tx = cfg.flip[0] ? ew_s - coord_t'(1) - sx : sx;
        ty = cfg.flip[1] ? eh_s - coord_t'(1) - sy : sy;
        vis = (tx >= 0) && (tx < ew_s) && (ty >= 0) && (ty < eh_s);
        dsh = 3'd4 - cfg.contrast[2:0] + {2'b00, tx[0] ^ ty[0]};
        iv = ((BITS_PER_PIXEL > 1) && (cfg.contrast < 8'd4)) ? (req.val >> dsh) : req.val;
        pvf = iv >> (8 - BITS_PER_PIXEL);
        pix = pvf[BITS_PER_PIXEL-1:0] ^ PIX_MASK[BITS_PER_PIXEL-1:0];
    end

    always_comb
    begin
        lin = 12'((int'(cfg.eh) * BITS_PER_PIXEL + 7) >> 3);
        dx = cfg.ew - 9'd1 - {1'b0, x_reg};
        yoff = 8'((int'(y_reg) * BITS_PER_PIXEL) >> 3);
        addr_full = (21'(lin) * 21'(dx)) + 21'(yoff);
        addr_ok = vis_reg && (addr_full < 21'(FRAME_BYTES));
        shift = 3'(8 - BITS_PER_PIXEL - int'(y_reg & 8'(PPB - 1)) * BITS_PER_PIXEL);
    end

    always_comb
    begin
        old_pix = (rdata_q >> shift_reg) & PIX_MASK;
        differ = old_pix != 8'(pix_reg);
        new_byte = (rdata_q & ~(PIX_MASK << shift_reg)) | (8'(pix_reg) << shift_reg);
        mem_we = (state_reg == U_CLEAR) || ((state_reg == U_CMP) && !is_rd_reg && differ);
        mem_waddr = (state_reg == U_CLEAR) ? clr_cnt_reg : mem_addr_reg;
        mem_wdata = (state_reg == U_CLEAR) ? 8'd0 : new_byte;
    end

    assign ready = state_reg == U_IDLE;

    always_comb
    begin
        rsp.done = ((state_reg == U_ADDR) && !addr_ok) || (state_reg == U_CMP);
        rsp.changed = (state_reg == U_CMP) && !is_rd_reg && differ;
        rsp.rdata = rdata_q;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_q <= mem[mem_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= U_CLEAR;
            clr_cnt_reg  <= '0;
            is_rd_reg    <= 1'b0;
            vis_reg      <= 1'b0;
            x_reg        <= '0;
            y_reg        <= '0;
            pix_reg      <= '0;
            shift_reg    <= '0;
            mem_addr_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                U_CLEAR:
                begin
                    if (clr_cnt_reg == AW'(FRAME_BYTES - 1))
                    begin
                        state_reg <= U_IDLE;
                    end
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                U_IDLE:
                begin
                    if (req.rd)
                    begin
                        is_rd_reg    <= 1'b1;
                        mem_addr_reg <= req.raddr;
                        state_reg    <= U_READ;
                    end
                    else if (req.plot)
                    begin
                        is_rd_reg <= 1'b0;
                        vis_reg   <= vis;
                        x_reg     <= tx[7:0];
                        y_reg     <= ty[7:0];
                        pix_reg   <= pix;
                        state_reg <= U_ADDR;
                    end
                end
                U_ADDR:
                begin
                    shift_reg    <= shift;
                    mem_addr_reg <= addr_full[AW-1:0];
                    state_reg    <= addr_ok ? U_READ : U_IDLE;
                end
                U_READ:
                begin
                    state_reg <= U_CMP;
                end
                U_CMP:
                begin
                    state_reg <= U_IDLE;
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- sv/packed_framebuffer_rect_plotter.sv -----
// Top level of the packed framebuffer rectangle plotter: command sequencer,
// cursor, configuration registers and result register. Depends on pfrp_pkg,
// pfrp_if and pfrp_pixel_unit.
//
// After reset the 8192-byte frame memory is swept to zero, one byte a cycle,
// and no command is taken until the sweep ends (configuration writes are).
// Commands then run one at a time. Pixel, box, fill and clear pass each
// pixel visited in turn through the single read-modify-write pixel unit.
// A box visits 2*width + 2*(height-2) pixels, a fill its on-screen
// area, a clear the whole display. The result waits in an output register,
// and the next command may be taken while it is still held.
module packed_framebuffer_rect_plotter
    import pfrp_pkg::*;
#(
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
    parameter int BITS_PER_PIXEL = DEF_BITS_PER_PIXEL
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    pfrp_cmd_if.sink    cmd,
    pfrp_rsp_if.source  rsp
);

    typedef enum logic [2:0] {
        S_IDLE, S_FBOUND, S_SETUP, S_ISSUE, S_WAIT, S_READ, S_RWAIT, S_FINISH
    } state_t;

    typedef enum logic [1:0] {M_AREA, M_BOXH, M_BOXV} mode_t;

    // configuration
    logic [2:0] flip_reg;
    logic [8:0] dw_reg;
    logic [8:0] dh_reg;
    logic [7:0] contrast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_reg     <= 3'd0;
            dw_reg       <= 9'd128;
            dh_reg       <= 9'd128;
            contrast_reg <= 8'd255;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FLIP:     flip_reg <= cfg_data[2:0];
                CFG_WIDTH:    dw_reg <= cfg_data;
                CFG_HEIGHT:   dh_reg <= cfg_data;
                CFG_CONTRAST: contrast_reg <= (cfg_data[7:0] == 8'd0) ? 8'd255 : cfg_data[7:0];
                default:      flip_reg <= flip_reg;
            endcase
        end
    end

    pfrp_cfg_t cfg;
    always_comb
    begin
        cfg.flip = flip_reg;
        cfg.ew = (dw_reg > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : dw_reg;
        cfg.eh = (dh_reg > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : dh_reg;
        cfg.contrast = contrast_reg;
    end

    // sequencer state
    state_t      state_reg;
    mode_t       mode_reg;
    coord_t      bx_reg, by_reg, bw_reg, bh_reg;
    coord_t      i_reg, i_end_reg, j_reg, j_start_reg, j_end_reg;
    logic [7:0]  val_reg;
    logic [12:0] raddr_reg;
    logic [7:0]  rdata_reg;
    logic        changed_reg;
    logic [11:0] cursor_x_reg, cursor_y_reg;
    logic [5:0]  align_reg;
    logic        dirty_reg;

    logic        out_valid_reg;
    logic [7:0]  out_rdata_reg;
    logic        out_changed_reg;
    logic        out_dirty_reg;
    logic [11:0] out_cx_reg, out_cy_reg;

    pfrp_req_t req;
    pfrp_rsp_t prsp;
    logic      px_ready;

    pfrp_pixel_unit #(
        .BITS_PER_PIXEL(BITS_PER_PIXEL)
    ) u_pixel (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .ready (px_ready),
        .rsp   (prsp)
    );

    // box placement on the cursor
    coord_t cx14, cy14, wv, hv, half_w, half_h, off_w, off_h;
    coord_t place_l, place_t, adv_x, adv_y;
    always_comb
    begin
        cx14 = coord_t'($signed(cursor_x_reg));
        cy14 = coord_t'($signed(cursor_y_reg));
        wv = $signed({4'd0, cmd.rect_width});
        hv = $signed({4'd0, cmd.rect_height});
        half_w = (wv == 0) ? coord_t'(0) : ((wv - coord_t'(1)) >>> 1);
        half_h = (hv == 0) ? coord_t'(0) : ((hv - coord_t'(1)) >>> 1);
        off_w = (align_reg[1:0] == 2'b11) ? half_w :
                align_reg[1] ? wv - coord_t'(1) : coord_t'(0);
        off_h = (align_reg[3:2] == 2'b11) ? half_h :
                align_reg[3] ? hv - coord_t'(1) : coord_t'(0);
        place_l = cx14 - off_w;
        place_t = cy14 - off_h;
        adv_x = cx14 + ((align_reg[4] && align_reg[0]) ? wv : coord_t'(0))
                     - ((align_reg[4] && align_reg[1]) ? wv : coord_t'(0));
        adv_y = cy14 + ((align_reg[5] && align_reg[2]) ? hv : coord_t'(0))
                     - ((align_reg[5] && align_reg[3]) ? hv : coord_t'(0));
    end

    // fill bounds clipped to the logical display
    coord_t lx, ly, c0, c1, r0, r1, dxl, dyl;
    always_comb
    begin
        lx = flip_reg[2] ? $signed({5'd0, cfg.eh}) : $signed({5'd0, cfg.ew});
        ly = flip_reg[2] ? $signed({5'd0, cfg.ew}) : $signed({5'd0, cfg.eh});
        dxl = lx - bx_reg;
        dyl = ly - by_reg;
        c0 = (bx_reg < 0) ? -bx_reg : coord_t'(0);
        c1 = (dxl < bw_reg) ? dxl : bw_reg;
        r0 = (by_reg < 0) ? -by_reg : coord_t'(0);
        r1 = (dyl < bh_reg) ? dyl : bh_reg;
    end

    // current pixel
    coord_t px, py;
    always_comb
    begin
        case (mode_reg)
            M_BOXH:
            begin
                px = bx_reg + j_reg;
                py = i_reg[0] ? by_reg + bh_reg - coord_t'(1) : by_reg;
            end
            M_BOXV:
            begin
                px = i_reg[0] ? bx_reg + bw_reg - coord_t'(1) : bx_reg;
                py = by_reg + j_reg;
            end
            default:
            begin
                px = bx_reg + j_reg;
                py = by_reg + i_reg;
            end
        endcase
        req.plot = state_reg == S_ISSUE;
        req.rd = state_reg == S_READ;
        req.x = px;
        req.y = py;
        req.val = val_reg;
        req.raddr = raddr_reg;
    end

    coord_t j_inc, i_inc;
    logic   accept, out_free;
    assign j_inc = j_reg + coord_t'(1);
    assign i_inc = i_reg + coord_t'(1);
    assign cmd.ready = (state_reg == S_IDLE) && px_ready;
    assign accept = cmd.valid && cmd.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mode_reg        <= M_AREA;
            bx_reg          <= '0;
            by_reg          <= '0;
            bw_reg          <= '0;
            bh_reg          <= '0;
            i_reg           <= '0;
            i_end_reg       <= '0;
            j_reg           <= '0;
            j_start_reg     <= '0;
            j_end_reg       <= '0;
            val_reg         <= '0;
            raddr_reg       <= '0;
            rdata_reg       <= '0;
            changed_reg     <= 1'b0;
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
            align_reg       <= ALIGN_DEFAULT;
            dirty_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_rdata_reg   <= '0;
            out_changed_reg <= 1'b0;
            out_dirty_reg   <= 1'b0;
            out_cx_reg      <= '0;
            out_cy_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready && !((state_reg == S_FINISH) && out_free))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        val_reg     <= cmd.intensity;
                        raddr_reg   <= cmd.byte_address;
                        rdata_reg   <= 8'd0;
                        changed_reg <= 1'b0;
                        i_reg       <= '0;
                        j_reg       <= '0;
                        j_start_reg <= '0;
                        bw_reg      <= wv;
                        bh_reg      <= hv;
                        unique case (cmd.op) inside
                            OP_SET_CURSOR:
                            begin
                                cursor_x_reg <= cmd.pos_x;
                                cursor_y_reg <= cmd.pos_y;
                                align_reg <= (cmd.align_bits == 6'd0) ? ALIGN_DEFAULT
                                                                      : cmd.align_bits;
                                state_reg <= S_FINISH;
                            end
                            OP_PIXEL:
                            begin
                                mode_reg  <= M_AREA;
                                bx_reg    <= coord_t'(cmd.pos_x);
                                by_reg    <= coord_t'(cmd.pos_y);
                                i_end_reg <= coord_t'(1);
                                j_end_reg <= coord_t'(1);
                                state_reg <= S_SETUP;
                            end
                            OP_BOX, OP_FILL:
                            begin
                                bx_reg       <= place_l;
                                by_reg       <= place_t;
                                cursor_x_reg <= adv_x[11:0];
                                cursor_y_reg <= adv_y[11:0];
                                if (cmd.op == OP_BOX)
                                begin
                                    mode_reg  <= M_BOXH;
                                    i_end_reg <= coord_t'(2);
                                    j_end_reg <= wv;
                                    state_reg <= S_SETUP;
                                end
                                else
                                begin
                                    mode_reg  <= M_AREA;
                                    state_reg <= S_FBOUND;
                                end
                            end
                            OP_CLEAR:
                            begin
                                mode_reg  <= M_AREA;
                                bx_reg    <= '0;
                                by_reg    <= '0;
                                i_end_reg <= $signed({5'd0, cfg.eh});
                                j_end_reg <= $signed({5'd0, cfg.ew});
                                state_reg <= S_SETUP;
                            end
                            OP_READ:
                            begin
                                state_reg <= S_READ;
                            end
                            OP_ACK:
                            begin
                                dirty_reg <= 1'b0;
                                state_reg <= S_FINISH;
                            end
                            default:
                            begin
                                state_reg <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_FBOUND:
                begin
                    i_reg       <= r0;
                    i_end_reg   <= r1;
                    j_reg       <= c0;
                    j_start_reg <= c0;
                    j_end_reg   <= c1;
                    state_reg   <= S_SETUP;
                end
                S_SETUP:
                begin
                    if ((i_reg < i_end_reg) && (j_reg < j_end_reg))
                    begin
                        state_reg <= S_ISSUE;
                    end
                    else if (mode_reg == M_BOXH)
                    begin
                        mode_reg    <= M_BOXV;
                        i_reg       <= '0;
                        i_end_reg   <= coord_t'(2);
                        j_reg       <= coord_t'(1);
                        j_start_reg <= coord_t'(1);
                        j_end_reg   <= bh_reg - coord_t'(1);
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_ISSUE:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (prsp.done)
                    begin
                        if (prsp.changed)
                        begin
                            changed_reg <= 1'b1;
                            dirty_reg   <= 1'b1;
                        end
                        if (j_inc < j_end_reg)
                        begin
                            j_reg     <= j_inc;
                            state_reg <= S_ISSUE;
                        end
                        else if (i_inc < i_end_reg)
                        begin
                            i_reg     <= i_inc;
                            j_reg     <= j_start_reg;
                            state_reg <= S_ISSUE;
                        end
                        else if (mode_reg == M_BOXH)
                        begin
                            mode_reg    <= M_BOXV;
                            i_reg       <= '0;
                            i_end_reg   <= coord_t'(2);
                            j_reg       <= coord_t'(1);
                            j_start_reg <= coord_t'(1);
                            j_end_reg   <= bh_reg - coord_t'(1);
                            state_reg   <= S_SETUP;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_RWAIT;
                end
                S_RWAIT:
                begin
                    if (prsp.done)
                    begin
                        rdata_reg <= prsp.rdata;
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_rdata_reg   <= rdata_reg;
                        out_changed_reg <= changed_reg;
                        out_dirty_reg   <= dirty_reg;
                        out_cx_reg      <= cursor_x_reg;
                        out_cy_reg      <= cursor_y_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_data    = out_rdata_reg;
    assign rsp.any_changed  = out_changed_reg;
    assign rsp.frame_dirty  = out_dirty_reg;
    assign rsp.cursor_x_out = out_cx_reg;
    assign rsp.cursor_y_out = out_cy_reg;

endmodule

// ----- sv/pfrp_checker.sv -----
// Port-level checks for the rectangle plotter, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pfrp_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] rsp_read_data,
    input logic       rsp_any_changed,
    input logic       rsp_frame_dirty
);

    // one command at a time: busy straight after a transaction
    `PFRP_ASSERT(chk_busy_after_cmd, (cmd_valid && cmd_ready) |=> !cmd_ready, "ready after accept")

    // a changed pixel always leaves the frame dirty
    `PFRP_NEVER(chk_changed_dirty, rsp_valid && rsp_any_changed && !rsp_frame_dirty, "changed but clean")

    `PFRP_ASSERT(chk_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_data) && $stable(rsp_frame_dirty)), "stalled result moved")

endmodule

bind packed_framebuffer_rect_plotter pfrp_checker u_pfrp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_read_data   (rsp.read_data),
    .rsp_any_changed (rsp.any_changed),
    .rsp_frame_dirty (rsp.frame_dirty)
);

// ----- test/packed_framebuffer_rect_plotter_tb.sv -----
// Self-checking testbench for packed_framebuffer_rect_plotter: directed and random drawing
// commands in several display settings, every result checked against an in-bench model.
// Depends on pfrp_pkg, pfrp_if and the plotter RTL.
module packed_framebuffer_rect_plotter_tb;
    import pfrp_pkg::*;

    localparam int BPP       = DEF_BITS_PER_PIXEL;
    localparam int MAXW      = DEF_MAX_WIDTH;
    localparam int MAXH      = DEF_MAX_HEIGHT;
    localparam int CYC_LIMIT = 20000000;
    localparam int LONG_HOLD = 400;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef struct {
        logic [2:0]  op;
        logic [11:0] px;
        logic [11:0] py;
        logic [5:0]  al;
        logic [9:0]  w;
        logic [9:0]  h;
        logic [7:0]  iv;
        logic [12:0] ba;
    } draw_cmd_t;

    typedef struct {
        logic [7:0]  rd;
        logic        ch;
        logic        dirty;
        logic [11:0] cx;
        logic [11:0] cy;
    } draw_rsp_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [8:0] cfg_data;

    pfrp_cmd_if cmd_ch();
    pfrp_rsp_if rsp_ch();

    packed_framebuffer_rect_plotter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch)
    );

    // shadow of the frame and control state
    logic [7:0]  fb [FRAME_BYTES];
    logic [11:0] m_cx, m_cy;
    logic [5:0]  m_al;
    logic        m_dirty;
    logic [2:0]  m_flip;
    logic [8:0]  m_dw, m_dh;
    logic [7:0]  m_contrast;

    draw_cmd_t pending_cmds[$];
    draw_rsp_t expected_rsps[$];
    int        errors;
    int        cycles;
    bit        quiet;
    bit        hold_req;
    bit        hold_done;
    int        cmd_gap;
    int        rsp_gap;

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int eff_w();
        return (m_dw > MAXW) ? MAXW : int'(m_dw);
    endfunction

    function automatic int eff_h();
        return (m_dh > MAXH) ? MAXH : int'(m_dh);
    endfunction

    function automatic int sx12(logic [11:0] v);
        return int'($signed(v));
    endfunction

    function automatic int draw_idle();
        return quiet ? 0 : int'($urandom_range(0, 12));
    endfunction

    function automatic bit plot_pixel(int xi, int yi, logic [7:0] val);
        int w, h, x, y, t, shift, line, addr;
        int unsigned i, bits, ppb;
        w = eff_w();
        h = eff_h();
        x = xi;
        y = yi;
        if (m_flip[2])
        begin
            t = x;
            x = y;
            y = t;
        end
        if (m_flip[0]) x = w - 1 - x;
        if (m_flip[1]) y = h - 1 - y;
        if (x < 0 || x >= w || y < 0 || y >= h) return 1'b0;
        i = val;
        if (BPP > 1 && m_contrast < 4) i = i >> (4 - m_contrast + ((x ^ y) & 1));
        bits  = (1 << BPP) - 1;
        ppb   = 8 / BPP;
        shift = 8 - (y % ppb) * BPP - BPP;
        line  = (h * BPP + 7) / 8;
        addr  = line * (w - 1 - x) + y * BPP / 8;
        if (addr >= FRAME_BYTES) return 1'b0;
        i = ((i >> (8 - BPP)) & bits) ^ bits;
        if (((fb[addr] >> shift) & bits) == i) return 1'b0;
        fb[addr] = 8'((fb[addr] & ~(bits << shift)) | (i << shift));
        m_dirty  = 1'b1;
        return 1'b1;
    endfunction

    // top-left of a box on the cursor; advances the cursor
    function automatic void place_box(int w, int h, output int l, output int t);
        int cx, cy;
        cx = sx12(m_cx);
        cy = sx12(m_cy);
        l  = cx;
        t  = cy;
        if (m_al[1:0] == 2'b11) l -= (w - 1) / 2;
        else if (m_al[1]) l -= (w - 1);
        if (m_al[3:2] == 2'b11) t -= (h - 1) / 2;
        else if (m_al[3]) t -= (h - 1);
        if (m_al[4])
        begin
            if (m_al[0]) cx += w;
            if (m_al[1]) cx -= w;
        end
        if (m_al[5])
        begin
            if (m_al[2]) cy += h;
            if (m_al[3]) cy -= h;
        end
        m_cx = cx[11:0];
        m_cy = cy[11:0];
    endfunction

    function automatic draw_rsp_t predict_draw(draw_cmd_t c);
        draw_rsp_t r;
        int w, h, l, t, n, lx, ly, c0, c1, r0, r1, rr, cc;
        bit ch;
        w  = c.w;
        h  = c.h;
        ch = 1'b0;
        r.rd = 8'd0;
        case (c.op)
            OP_SET_CURSOR:
            begin
                m_cx = c.px;
                m_cy = c.py;
                m_al = (c.al != 0) ? c.al : ALIGN_DEFAULT;
            end
            OP_PIXEL: ch |= plot_pixel(sx12(c.px), sx12(c.py), c.iv);
            OP_BOX:
            begin
                place_box(w, h, l, t);
                for (n = 0; n < w; n++)
                begin
                    ch |= plot_pixel(l + n, t, c.iv);
                    ch |= plot_pixel(l + n, t + h - 1, c.iv);
                end
                for (n = 1; n < h - 1; n++)
                begin
                    ch |= plot_pixel(l, t + n, c.iv);
                    ch |= plot_pixel(l + w - 1, t + n, c.iv);
                end
            end
            OP_FILL:
            begin
                place_box(w, h, l, t);
                lx = m_flip[2] ? eff_h() : eff_w();
                ly = m_flip[2] ? eff_w() : eff_h();
                c0 = (l < 0) ? -l : 0;
                c1 = (lx - l < w) ? lx - l : w;
                r0 = (t < 0) ? -t : 0;
                r1 = (ly - t < h) ? ly - t : h;
                for (rr = r0; rr < r1; rr++)
                    for (cc = c0; cc < c1; cc++)
                        ch |= plot_pixel(l + cc, t + rr, c.iv);
            end
            OP_CLEAR:
            begin
                for (rr = 0; rr < eff_h(); rr++)
                    for (cc = 0; cc < eff_w(); cc++)
                        ch |= plot_pixel(cc, rr, c.iv);
            end
            OP_READ: r.rd = fb[c.ba];
            OP_ACK:  m_dirty = 1'b0;
            default: ;
        endcase
        r.ch    = ch;
        r.dirty = m_dirty;
        r.cx    = m_cx;
        r.cy    = m_cy;
        return r;
    endfunction

    task automatic report(string field, int got, int want);
        errors++;
        $display("mismatch on %s: got %0h, expected %0h", field, got, want);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_FLIP:   m_flip = val[2:0];
            CFG_WIDTH:  m_dw = val;
            CFG_HEIGHT: m_dh = val;
            default:    m_contrast = (val[7:0] == 0) ? 8'd255 : val[7:0];
        endcase
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_cmds.size() != 0 || expected_rsps.size() != 0 || cmd_ch.valid)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic draw_cmd_t mk_cmd(logic [2:0] op, int x, int y, logic [5:0] al,
                                         int w, int h, logic [7:0] iv, int ba);
        draw_cmd_t c;
        c.op = op;
        c.px = x[11:0];
        c.py = y[11:0];
        c.al = al;
        c.w  = w[9:0];
        c.h  = h[9:0];
        c.iv = iv;
        c.ba = ba[12:0];
        return c;
    endfunction

    function automatic draw_cmd_t rand_cmd();
        draw_cmd_t c;
        int sel, area, used;
        bit big_ok;
        area   = eff_w() * eff_h();
        big_ok = (area <= 4096);
        used   = ((eff_h() * BPP + 7) / 8) * eff_w();
        if (used < 1) used = 1;
        sel  = $urandom_range(0, 99);
        if (sel < 15) c.op = OP_SET_CURSOR;
        else if (sel < 40) c.op = OP_PIXEL;
        else if (sel < 55) c.op = OP_BOX;
        else if (sel < 75) c.op = OP_FILL;
        else if (sel < 88) c.op = OP_READ;
        else if (sel < 94) c.op = OP_ACK;
        else if (sel < 97) c.op = OP_UNUSED;
        else c.op = (area <= 1024) ? OP_CLEAR : OP_PIXEL;
        if ($urandom_range(0, 9) == 0)
        begin
            c.px = 12'($urandom());
            c.py = 12'($urandom());
        end
        else
        begin
            c.px = 12'($urandom_range(0, eff_w() + 40) - 20);
            c.py = 12'($urandom_range(0, eff_h() + 40) - 20);
        end
        c.al = 6'($urandom());
        if (big_ok && $urandom_range(0, 30) == 0)
        begin
            c.w = 10'($urandom());
            c.h = 10'($urandom_range(0, 3));
            if ($urandom_range(0, 1)) {c.w, c.h} = {c.h, c.w};
        end
        else
        begin
            c.w = 10'($urandom_range(0, 24));
            c.h = 10'($urandom_range(0, 24));
        end
        c.iv = 8'($urandom());
        c.ba = ($urandom_range(0, 4) == 0) ? 13'($urandom()) : 13'($urandom_range(0, used - 1));
        return c;
    endfunction

    task automatic run_phase(logic [2:0] fl, logic [8:0] w, logic [8:0] h, logic [8:0] con,
                             int n, bit with_clear);
        wait_idle();
        write_reg(CFG_FLIP, {6'd0, fl});
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_CONTRAST, con);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (with_clear) pending_cmds.push_back(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 8'hFF, 0));
        for (int k = 0; k < n; k++)
        begin
            if (k % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
            pending_cmds.push_back(rand_cmd());
        end
    endtask

    // command driver
    always @(posedge clk)
    begin
        bit        acc;
        bit        nv;
        draw_cmd_t c;
        cycles++;
        if (cycles > CYC_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else if (rst_n)
        begin
            acc = cmd_ch.valid && cmd_ch.ready;
            nv  = cmd_ch.valid;
            if (acc)
            begin
                c.op = cmd_ch.op;
                c.px = cmd_ch.pos_x;
                c.py = cmd_ch.pos_y;
                c.al = cmd_ch.align_bits;
                c.w  = cmd_ch.rect_width;
                c.h  = cmd_ch.rect_height;
                c.iv = cmd_ch.intensity;
                c.ba = cmd_ch.byte_address;
                expected_rsps.push_back(predict_draw(c));
                cmd_gap = draw_idle();
            end
            if (cmd_ch.valid && !acc)
                nv = 1'b1;
            else if (cmd_gap > 0)
            begin
                cmd_gap--;
                nv = 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                c = pending_cmds.pop_front();
                cmd_ch.op           <= c.op;
                cmd_ch.pos_x        <= c.px;
                cmd_ch.pos_y        <= c.py;
                cmd_ch.align_bits   <= c.al;
                cmd_ch.rect_width   <= c.w;
                cmd_ch.rect_height  <= c.h;
                cmd_ch.intensity    <= c.iv;
                cmd_ch.byte_address <= c.ba;
                nv = 1'b1;
            end
            else
                nv = 1'b0;
            cmd_ch.valid <= nv;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        bit        acc;
        draw_rsp_t e;
        if (rst_n)
        begin
            acc = rsp_ch.valid && rsp_ch.ready;
            if (acc)
            begin
                if (expected_rsps.size() == 0)
                begin
                    errors++;
                    $display("result transaction with nothing outstanding");
                end
                else
                begin
                    e = expected_rsps.pop_front();
                    if (rsp_ch.read_data !== e.rd) report("read_data", rsp_ch.read_data, e.rd);
                    if (rsp_ch.any_changed !== e.ch)
                        report("any_changed", rsp_ch.any_changed, e.ch);
                    if (rsp_ch.frame_dirty !== e.dirty)
                        report("frame_dirty", rsp_ch.frame_dirty, e.dirty);
                    if (rsp_ch.cursor_x_out !== e.cx)
                        report("cursor_x_out", rsp_ch.cursor_x_out, e.cx);
                    if (rsp_ch.cursor_y_out !== e.cy)
                        report("cursor_y_out", rsp_ch.cursor_y_out, e.cy);
                end
                rsp_gap = draw_idle();
            end
            if (hold_req && !hold_done)
            begin
                rsp_gap   = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (rsp_gap > 0)
            begin
                rsp_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_FLIP;
        cfg_data   = 9'd0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.op           = OP_SET_CURSOR;
        cmd_ch.pos_x        = 12'd0;
        cmd_ch.pos_y        = 12'd0;
        cmd_ch.align_bits   = 6'd0;
        cmd_ch.rect_width   = 10'd0;
        cmd_ch.rect_height  = 10'd0;
        cmd_ch.intensity    = 8'd0;
        cmd_ch.byte_address = 13'd0;
        rsp_ch.ready        = 1'b0;
        errors     = 0;
        cycles     = 0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        cmd_gap    = 0;
        rsp_gap    = 0;
        for (int a = 0; a < FRAME_BYTES; a++) fb[a] = 8'd0;
        m_cx       = 12'd0;
        m_cy       = 12'd0;
        m_al       = ALIGN_DEFAULT;
        m_dirty    = 1'b0;
        m_flip     = 3'd0;
        m_dw       = 9'd128;
        m_dh       = 9'd128;
        m_contrast = 8'd255;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed part on reset settings
        pending_cmds.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 8191));
        pending_cmds.push_back(mk_cmd(OP_SET_CURSOR, -2048, 2047, 6'd0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(OP_FILL, 0, 0, 0, 5, 5, 8'hFF, 0));
        pending_cmds.push_back(mk_cmd(OP_PIXEL, 0, 0, 0, 0, 0, 8'h00, 0));
        pending_cmds.push_back(mk_cmd(OP_PIXEL, 127, 127, 0, 0, 0, 8'hFF, 0));
        pending_cmds.push_back(mk_cmd(OP_PIXEL, 127, 127, 0, 0, 0, 8'hFF, 0));
        pending_cmds.push_back(mk_cmd(OP_PIXEL, -1, 128, 0, 0, 0, 8'h00, 0));
        pending_cmds.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 2047));
        pending_cmds.push_back(mk_cmd(OP_ACK, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(OP_SET_CURSOR, 2047, -2048, 6'd63, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(OP_BOX, 0, 0, 0, 1023, 1023, 8'h00, 0));
        pending_cmds.push_back(mk_cmd(OP_SET_CURSOR, 10, 10, 6'd63, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(OP_BOX, 0, 0, 0, 0, 0, 8'h00, 0));
        pending_cmds.push_back(mk_cmd(OP_BOX, 0, 0, 0, 1, 1, 8'h00, 0));
        pending_cmds.push_back(mk_cmd(OP_FILL, 0, 0, 0, 7, 4, 8'h00, 0));
        pending_cmds.push_back(mk_cmd(OP_SET_CURSOR, -3, -3, 6'd58, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(OP_FILL, 0, 0, 0, 9, 9, 8'h80, 0));
        pending_cmds.push_back(mk_cmd(OP_SET_CURSOR, 0, 0, 6'd0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(OP_FILL, 0, 0, 0, 128, 128, 8'h00, 0));
        pending_cmds.push_back(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 8'hFF, 0));
        pending_cmds.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 100));
        pending_cmds.push_back(mk_cmd(OP_UNUSED, 5, 5, 6'd5, 5, 5, 8'h7F, 0));
        pending_cmds.push_back(mk_cmd(OP_ACK, 0, 0, 0, 0, 0, 0, 0));

        run_phase(3'd0, 9'd128, 9'd128, 9'd255, 110, 1'b0);
        run_phase(3'd1, 9'd64, 9'd32, 9'd0, 80, 1'b1);
        hold_req = 1'b1;
        run_phase(3'd4, 9'd40, 9'd24, 9'd3, 80, 1'b1);
        run_phase(3'd7, 9'd1, 9'd1, 9'd1, 60, 1'b1);
        run_phase(3'd3, 9'd511, 9'd8, 9'd128, 80, 1'b1);
        run_phase(3'd6, 9'd0, 9'd17, 9'd255, 60, 1'b1);
        run_phase(3'd2, 9'd8, 9'd256, 9'd2, 80, 1'b1);
        run_phase(3'd5, 9'd256, 9'd256, 9'd4, 70, 1'b0);
        wait_idle();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
